[hdl/wss_pkg.sv]
// shared types and constants for the wildcard signature scanner
`timescale 1ns / 1ps
package wss_pkg;
	localparam int PATTERN_MAX_DEF = 32;
	localparam int OFFSET_BITS_DEF = 32;

	localparam int PAT_SLOTS = 32;
	localparam int PAT_IDX_W = 5;
	localparam int LEN_W = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int MASK_W = 32;
	localparam int MATCH_OFFSET_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_MID_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_MID_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WILDCARD     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH       = 3'd5;

	typedef logic [7:0] byte_t;
	typedef logic [PAT_SLOTS-1:0][7:0] pattern_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic counted;
	} s1_ctrl_t;
endpackage

[hdl/wss_ifaces.sv]
// valid/ready channel interfaces for scan bytes and scan results
`timescale 1ns / 1ps
interface wss_scan_if import wss_pkg::*;;
	logic  valid;
	logic  ready;
	byte_t scan_byte;
	logic  last_byte;

	modport source(output valid, output scan_byte, output last_byte, input ready);
	modport sink(input valid, input scan_byte, input last_byte, output ready);
endinterface

interface wss_result_if import wss_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [MATCH_OFFSET_W-1:0] match_offset;

	modport source(output valid, output found, output match_offset, input ready);
	modport sink(input valid, input found, input match_offset, output ready);
endinterface

[hdl/wss_cfg_regs.sv]
// configuration registers: pattern bytes, wildcard mask and clamped length
`timescale 1ns / 1ps
module wss_cfg_regs import wss_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output pattern_t              pattern,
	output logic [MASK_W-1:0]     wild_mask,
	output logic [LEN_W-1:0]      eff_len
);
	localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(PATTERN_MAX);

	logic [CFG_DATA_W-1:0] pat_low_q, pat_mid_low_q, pat_mid_high_q, pat_high_q;
	logic [MASK_W-1:0]     mask_q;
	logic [LEN_W-1:0]      len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q      <= '0;
			pat_mid_low_q  <= '0;
			pat_mid_high_q <= '0;
			pat_high_q     <= '0;
			mask_q         <= '0;
			len_q          <= LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAT_LOW:      pat_low_q      <= cfg_wdata;
				REG_PAT_MID_LOW:  pat_mid_low_q  <= cfg_wdata;
				REG_PAT_MID_HIGH: pat_mid_high_q <= cfg_wdata;
				REG_PAT_HIGH:     pat_high_q     <= cfg_wdata;
				REG_WILDCARD:     mask_q         <= cfg_wdata[MASK_W-1:0];
				REG_LENGTH:       len_q          <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign pattern   = pattern_t'({pat_high_q, pat_mid_high_q, pat_mid_low_q, pat_low_q});
	assign wild_mask = mask_q;

	always_comb begin
		if (len_q == '0)
			eff_len = LEN_W'(1);
		else if (len_q > LEN_CAP)
			eff_len = LEN_CAP;
		else
			eff_len = len_q;
	end
endmodule

[hdl/wss_input_stage.sv]
// input stage: byte window shift line, per-image byte counter, stage 1 control
`timescale 1ns / 1ps
module wss_input_stage import wss_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	wss_scan_if.sink                            scan_in,
	input  logic                                s1_adv,
	output s1_ctrl_t                            ctrl_s1,
	output logic [OFFSET_BITS-1:0]              count_s1,
	output logic [PATTERN_MAX-1:0][7:0]         window_s1
);
	logic                   accept;
	logic                   counted;
	logic [OFFSET_BITS-1:0] count_q;
	logic [OFFSET_BITS-1:0] count_next;

	assign scan_in.ready = !ctrl_s1.valid || s1_adv;
	assign accept        = scan_in.valid && scan_in.ready;

	// counter saturates at all ones, bytes seen there never count
	assign counted    = count_q != '1;
	assign count_next = counted ? count_q + OFFSET_BITS'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ctrl_s1 <= '0;
		end else begin
			if (accept)
				count_q <= scan_in.last_byte ? '0 : count_next;
			if (accept) begin
				ctrl_s1.valid   <= 1'b1;
				ctrl_s1.last    <= scan_in.last_byte;
				ctrl_s1.counted <= counted;
			end else if (s1_adv) begin
				ctrl_s1.valid   <= 1'b0;
			end
		end
	end

	// newest byte in slot 0
	always_ff @(posedge clk) begin
		if (accept) begin
			window_s1[0] <= scan_in.scan_byte;
			for (int j = 1; j < PATTERN_MAX; j++)
				window_s1[j] <= window_s1[j-1];
			count_s1 <= count_next;
		end
	end

	a_count_clears_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && scan_in.last_byte) |=> (count_q == '0))
		else $error("byte counter not cleared after last beat");

	a_s1_holds_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_s1.valid && !s1_adv) |=> (ctrl_s1.valid && $stable(count_s1)))
		else $error("stage 1 item lost while stalled");

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_s1.valid && !s1_adv) |-> !scan_in.ready)
		else $error("scan beat accepted while stage 1 is full");
endmodule

[hdl/wss_match_stage.sv]
// masked window compare, first-match tracking and result register
`timescale 1ns / 1ps
module wss_match_stage import wss_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  s1_ctrl_t                    ctrl_s1,
	input  logic [OFFSET_BITS-1:0]      count_s1,
	input  logic [PATTERN_MAX-1:0][7:0] window_s1,
	input  pattern_t                    pattern,
	input  logic [MASK_W-1:0]           wild_mask,
	input  logic [LEN_W-1:0]            eff_len,
	output logic                        s1_adv,
	wss_result_if.source                result_out
);
	localparam int DIFF_W = (OFFSET_BITS > MATCH_OFFSET_W) ? OFFSET_BITS : MATCH_OFFSET_W;

	logic                      reported_q;
	logic                      out_vld_q;
	logic                      found_q;
	logic [MATCH_OFFSET_W-1:0] offset_q;

	logic [PATTERN_MAX-1:0] slot_ok;
	logic                   window_hit;
	logic                   long_enough;
	logic                   hit;
	logic                   has_result;
	logic [DIFF_W-1:0]      start_offset;

	// window slot j lines up with pattern position len-1-j
	always_comb begin
		for (int j = 0; j < PATTERN_MAX; j++) begin
			logic [LEN_W-1:0]     pos;
			logic [PAT_IDX_W-1:0] pidx;
			pos  = eff_len - LEN_W'(1) - LEN_W'(j);
			pidx = pos[PAT_IDX_W-1:0];
			slot_ok[j] = (LEN_W'(j) >= eff_len) || wild_mask[pidx]
				|| (window_s1[j] == pattern[pidx]);
		end
	end

	assign window_hit  = &slot_ok;
	assign long_enough = count_s1 >= OFFSET_BITS'(eff_len);
	assign hit         = !reported_q && ctrl_s1.counted && long_enough && window_hit;
	assign has_result  = hit || (ctrl_s1.last && !reported_q);
	assign start_offset = DIFF_W'(count_s1) - DIFF_W'(eff_len);

	assign s1_adv = !out_vld_q || result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= ctrl_s1.valid && has_result;
			if (ctrl_s1.valid) begin
				if (ctrl_s1.last)
					reported_q <= 1'b0;
				else if (hit)
					reported_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			found_q  <= hit;
			offset_q <= hit ? start_offset[MATCH_OFFSET_W-1:0] : '0;
		end
	end

	assign result_out.valid        = out_vld_q;
	assign result_out.found        = found_q;
	assign result_out.match_offset = offset_q;

	a_not_found_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !found_q) |-> (offset_q == '0))
		else $error("not-found beat carries a nonzero offset");

	a_reported_clears_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && ctrl_s1.valid && ctrl_s1.last) |=> !reported_q)
		else $error("match flag survived end of image");

	a_result_holds_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !result_out.ready) |=>
		(out_vld_q && $stable(found_q) && $stable(offset_q)))
		else $error("result beat changed while stalled");
endmodule

[hdl/wildcard_signature_scan.sv]
// Streaming wildcard byte-pattern search. One image byte is taken per beat
// on scan_in, and one item per clock is sustained while result_out does not
// stall: every byte passes through a single registered stage (the byte
// window shift line) into a parallel masked compare of all window slots, and
// its result, if any, is captured in the output register as the stage
// advances. Backpressure on result_out stalls the stage and then scan_in.
// Each image yields one result beat: the start offset of its first match,
// reported as soon as the match completes, or not-found on the last byte.
// Pattern, wildcard mask and length are to be written on the cfg port between
// images (not enforced by the block) and take effect from the next byte.
`timescale 1ns / 1ps
module wildcard_signature_scan import wss_pkg::*; #(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	wss_scan_if.sink              scan_in,
	wss_result_if.source          result_out
);
	pattern_t                    pattern;
	logic [MASK_W-1:0]           wild_mask;
	logic [LEN_W-1:0]            eff_len;
	s1_ctrl_t                    ctrl_s1;
	logic [OFFSET_BITS-1:0]      count_s1;
	logic [PATTERN_MAX-1:0][7:0] window_s1;
	logic                        s1_adv;

	wss_cfg_regs #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pattern   (pattern),
		.wild_mask (wild_mask),
		.eff_len   (eff_len)
	);

	wss_input_stage #(
		.PATTERN_MAX(PATTERN_MAX),
		.OFFSET_BITS(OFFSET_BITS)
	) u_input (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan_in   (scan_in),
		.s1_adv    (s1_adv),
		.ctrl_s1   (ctrl_s1),
		.count_s1  (count_s1),
		.window_s1 (window_s1)
	);

	wss_match_stage #(
		.PATTERN_MAX(PATTERN_MAX),
		.OFFSET_BITS(OFFSET_BITS)
	) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl_s1    (ctrl_s1),
		.count_s1   (count_s1),
		.window_s1  (window_s1),
		.pattern    (pattern),
		.wild_mask  (wild_mask),
		.eff_len    (eff_len),
		.s1_adv     (s1_adv),
		.result_out (result_out)
	);
endmodule
